// ===== hdl/itrd_pkg.sv =====
`default_nettype none
package itrd_pkg;

  localparam int IN_W        = 63;
  localparam int VALUE_WIDTH = 63;
  localparam int DIG_W       = 6;
  localparam int CHAR_W      = 7;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
  // one cell per possible base-2 digit
  localparam int NUM_CELLS   = VALUE_WIDTH;

  localparam logic [DIG_W-1:0]  RADIX_MIN   = DIG_W'(2);
  localparam logic [DIG_W-1:0]  RADIX_MAX   = DIG_W'(36);
  localparam logic [DIG_W-1:0]  RADIX_RESET = DIG_W'(10);
  localparam logic [DIG_W-1:0]  DEC_LIMIT   = DIG_W'(10);
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_LC_A  = CHAR_W'(97);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;  // zero the digit
    logic dbl;    // digit = 2*digit + carry, reduced by radix
    logic shift;  // take the digit of the cell below
  } cell_ctrl_t;

  function automatic logic [DIG_W-1:0] sat_radix(input logic [DIG_W-1:0] r);
    logic [DIG_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DEC_LIMIT) begin
      res = ASCII_ZERO + {1'b0, d};
    end else begin
      res = ASCII_LC_A + {1'b0, d - DEC_LIMIT};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/itrd_cell.sv =====
`default_nettype none
module itrd_cell (
  input  wire logic                     clk,
  input  wire itrd_pkg::cell_ctrl_t     ctrl,
  input  wire logic [itrd_pkg::DIG_W-1:0] radix,
  input  wire logic                     cin,
  input  wire logic [itrd_pkg::DIG_W-1:0] dig_in,
  output logic                          cout,
  output logic [itrd_pkg::DIG_W-1:0]    dig
);
  import itrd_pkg::*;

  logic [DIG_W-1:0] dig_r;
  logic [DIG_W-1:0] dig_nxt;
  logic [DIG_W:0]   twice;
  logic [DIG_W:0]   dbl_val;
  logic             gen;
  logic             prop;
  logic [DIG_W:0]   sub;

  // 2*d already reaches radix, or 2*d+1 hits it exactly and a carry arrives
  always_comb begin
    twice   = {dig_r, 1'b0};
    dbl_val = {dig_r, cin};
    gen     = twice >= {1'b0, radix};
    prop    = (twice + (DIG_W+1)'(1)) == {1'b0, radix};
    cout    = gen | (prop & cin);
    sub     = cout ? {1'b0, radix} : '0;
  end

  always_comb begin
    dig_nxt = dig_r;
    priority if (ctrl.clear) begin
      dig_nxt = '0;
    end else if (ctrl.dbl) begin
      dig_nxt = DIG_W'(dbl_val - sub);
    end else if (ctrl.shift) begin
      dig_nxt = dig_in;
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
  end

  assign dig = dig_r;

endmodule
`default_nettype wire

// ===== hdl/itrd_chain.sv =====
`default_nettype none
module itrd_chain (
  input  wire logic                       clk,
  input  wire itrd_pkg::cell_ctrl_t       ctrl,
  input  wire logic [itrd_pkg::DIG_W-1:0] radix,
  input  wire logic                       bit_in,
  output logic [itrd_pkg::DIG_W-1:0]      top_dig
);
  import itrd_pkg::*;

  logic [DIG_W-1:0] dig   [NUM_CELLS];
  logic             carry [NUM_CELLS];

  // cell 0 holds the least significant digit; carries ripple upward
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    logic             cin_w;
    logic [DIG_W-1:0] din_w;
    if (i == 0) begin : g_first
      assign cin_w = bit_in;
      assign din_w = '0;
    end else begin : g_rest
      assign cin_w = carry[i-1];
      assign din_w = dig[i-1];
    end
    itrd_cell u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .radix  (radix),
      .cin    (cin_w),
      .dig_in (din_w),
      .cout   (carry[i]),
      .dig    (dig[i])
    );
  end

  assign top_dig = dig[NUM_CELLS-1];

endmodule
`default_nettype wire

// ===== hdl/integer_to_radix_digits_core.sv =====
`default_nettype none
// Channel  Direction  Ports                                   Request moves
// in       input      in_valid, in_stall, in_value            one integer
// out      output     out_valid, out_stall, out_digit_char,   one ASCII digit
//                     out_last_digit
// cfg      input      cfg_wr_en, cfg_wr_data                  radix (reset 10)
//
// One integer at a time: conversion shifts one input bit through the
// chain of 63 digit cells per cycle, then 63 emit steps from the top cell, one
// digit or one skipped leading zero per cycle; output stalls hold only digit emits.
// in_stall is high until the run is done.
// Reset is synchronous, active low, and sets the radix to 10.
module integer_to_radix_digits_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [itrd_pkg::IN_W-1:0]     in_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [itrd_pkg::CHAR_W-1:0]        out_digit_char,
  output logic                               out_last_digit,
  input  wire logic                          cfg_wr_en,
  input  wire logic [itrd_pkg::DIG_W-1:0]    cfg_wr_data
);
  import itrd_pkg::*;

  state_t               state_r, state_nxt;
  logic [DIG_W-1:0]     radix_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [CNT_W-1:0]     bit_cnt_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 seen_r;
  logic                 out_valid_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic                 out_last_r;

  logic [DIG_W-1:0]     eff_radix;
  logic [DIG_W-1:0]     top_dig;
  logic                 in_acc;
  logic                 out_free;
  logic                 skip;
  logic                 emit_go;
  logic                 emit_out;
  cell_ctrl_t           ctrl;

  assign eff_radix = sat_radix(radix_r);
  assign in_acc    = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;

  itrd_chain u_chain (
    .clk     (clk),
    .ctrl    (ctrl),
    .radix   (eff_radix),
    .bit_in  (val_r[VALUE_WIDTH-1]),
    .top_dig (top_dig)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_CONV;
      ST_CONV: if (bit_cnt_r == CNT_W'(1)) state_nxt = ST_EMIT;
      ST_EMIT: if (emit_go && cnt_r == CNT_W'(1)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall   = 1'b1;
    skip       = 1'b0;
    emit_go    = 1'b0;
    emit_out   = 1'b0;
    ctrl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        ctrl.clear = in_valid;
      end
      ST_CONV: begin
        ctrl.dbl = 1'b1;
      end
      ST_EMIT: begin
        // drop leading zeros, but always keep the last digit
        skip       = (top_dig == '0) && !seen_r && (cnt_r > CNT_W'(1));
        emit_out   = !skip && out_free;
        emit_go    = skip || out_free;
        ctrl.shift = emit_go;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radix_r     <= RADIX_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) radix_r <= cfg_wr_data;
      if (emit_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      val_r     <= in_value[VALUE_WIDTH-1:0];
      bit_cnt_r <= CNT_W'(VALUE_WIDTH);
      cnt_r     <= CNT_W'(NUM_CELLS);
      seen_r    <= 1'b0;
    end else if (state_r == ST_CONV) begin
      val_r     <= {val_r[VALUE_WIDTH-2:0], 1'b0};
      bit_cnt_r <= bit_cnt_r - CNT_W'(1);
    end else if (emit_go) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (emit_out) seen_r <= 1'b1;
    end
    if (emit_out) begin
      out_char_r <= digit_char(top_dig);
      out_last_r <= (cnt_r == CNT_W'(1));
    end
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

endmodule
`default_nettype wire
